// ----- sv/sprp_pkg.sv -----
// Shared types and constants of the sprite screen projection block.
`default_nettype none
package sprp_pkg;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_PLAYER_X      = 3'd0,
      CSR_PLAYER_Y      = 3'd1,
      CSR_DIR_COS       = 3'd2,
      CSR_DIR_SIN       = 3'd3,
      CSR_PLANE_X       = 3'd4,
      CSR_PLANE_Y       = 3'd5,
      CSR_SCREEN_WIDTH  = 3'd6,
      CSR_SCREEN_HEIGHT = 3'd7
   } csr_idx_type;

   // Widths of the first division pass.
   localparam int DNUM_W = 46;
   localparam int DDEN_W = 32;

   // Item handed from the front part to the back part.
   typedef struct packed {
      logic [DNUM_W-1:0] dnum_mag;   // |numy| * 2^14
      logic [DDEN_W-1:0] det_mag;
      logic              depth_neg;
      logic              det_zero;
      logic [DNUM_W-1:0] cnum_mag;   // (w/2) * |numx + numy|
      logic [DDEN_W-1:0] numy_mag;
      logic              center_neg;
      logic              numy_zero;
   } item_type;

   // One finished result.
   typedef struct packed {
      logic signed [15:0] end_y;
      logic        [14:0] start_y;
      logic signed [15:0] end_x;
      logic        [14:0] start_x;
      logic signed [15:0] vertical_offset;
      logic        [14:0] sprite_size;
      logic signed [15:0] center_column;
      logic               in_front;
      logic signed [19:0] depth;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV1,
      ST_START2,
      ST_DIV2,
      ST_RECT
   } back_state_type;

endpackage
`default_nettype wire

// ----- sv/sprp_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module sprp_div #(
   parameter int N = 46,
   parameter int M = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [N-1:0] dividend,
   input  wire logic [M-1:0] divisor,
   output logic      [N-1:0] quotient,
   output logic              done
);
   localparam int CW = $clog2(N + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [M-1:0]  rem_ff, rem_in;
   logic [N-1:0]  quo_ff, quo_in;
   logic [M-1:0]  dvs_ff, dvs_in;
   logic [M:0]    rem_sh;
   logic [M+1:0]  diff;
   logic          ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[N-1]};
      diff    = {1'b0, rem_sh} - {2'b00, dvs_ff};
      ge      = ~diff[M+1];
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(N);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[M-1:0] : rem_sh[M-1:0];
         quo_in = {quo_ff[N-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;
endmodule
`default_nettype wire

// ----- sv/sprp_front.sv -----
// Front pipeline: camera-space transform of one sprite into a division job.
`default_nettype none
module sprp_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [7:0]         cell_x,
   input  wire logic [7:0]         cell_y,
   input  wire logic [15:0]        player_x,
   input  wire logic [15:0]        player_y,
   input  wire logic signed [15:0] dir_cos,
   input  wire logic signed [15:0] dir_sin,
   input  wire logic signed [15:0] plane_x,
   input  wire logic signed [15:0] plane_y,
   input  wire logic [12:0]        screen_width,
   input  wire logic               q_full,
   output logic                    q_push,
   output sprp_pkg::item_type      q_item
);
   logic adv;
   logic [6:1] v_ff, v_in;

   logic signed [17:0] sx_ff, sx_in, sy_ff, sy_in;
   logic signed [33:0] ssx_ff, ssx_in, csy_ff, csy_in, pysx_ff, pysx_in, pxsy_ff, pxsy_in;
   logic signed [31:0] pxs_ff, pxs_in, cpy_ff, cpy_in;
   logic signed [34:0] numx_ff, numx_in, numy_ff, numy_in;
   logic signed [32:0] det_ff, det_in;
   logic signed [35:0] csum_ff, csum_in;
   logic [31:0] nmag4_ff, nmag4_in, dmag4_ff, dmag4_in;
   logic dneg4_ff, dneg4_in, dz4_ff, dz4_in, nz4_ff, nz4_in, nneg4_ff, nneg4_in;
   logic [33:0] cmag5_ff, cmag5_in;
   logic [31:0] nmag5_ff, nmag5_in, dmag5_ff, dmag5_in;
   logic dneg5_ff, dneg5_in, dz5_ff, dz5_in, nz5_ff, nz5_in, cneg5_ff, cneg5_in;
   sprp_pkg::item_type item_ff, item_in;

   logic signed [34:0] numy_abs, det_abs;
   logic signed [35:0] csum_abs;

   assign adv        = !(v_ff[6] && q_full);
   assign req_tready = adv;
   assign q_push     = v_ff[6] && !q_full;
   assign q_item     = item_ff;

   always_comb begin
      v_in  = {v_ff[5:1], req_tvalid};
      sx_in = $signed({2'b00, cell_x, 8'h80}) - $signed({2'b00, player_x});
      sy_in = $signed({2'b00, cell_y, 8'h80}) - $signed({2'b00, player_y});

      ssx_in  = 34'(dir_sin * sx_ff);
      csy_in  = 34'(dir_cos * sy_ff);
      pysx_in = 34'(plane_y * sx_ff);
      pxsy_in = 34'(plane_x * sy_ff);
      pxs_in  = 32'(plane_x * dir_sin);
      cpy_in  = 32'(dir_cos * plane_y);

      numx_in = 35'(ssx_ff) - 35'(csy_ff);
      numy_in = 35'(pxsy_ff) - 35'(pysx_ff);
      det_in  = 33'(pxs_ff) - 33'(cpy_ff);

      numy_abs = numy_ff[34] ? -numy_ff : numy_ff;
      det_abs  = det_ff[32] ? -35'(det_ff) : 35'(det_ff);
      csum_in  = 36'(numx_ff) + 36'(numy_ff);
      nmag4_in = numy_abs[31:0];
      dmag4_in = det_abs[31:0];
      dneg4_in = numy_ff[34] ^ det_ff[32];
      nneg4_in = numy_ff[34];
      dz4_in   = (det_ff == '0);
      nz4_in   = (numy_ff == '0);

      csum_abs = csum_ff[35] ? -csum_ff : csum_ff;
      cmag5_in = csum_abs[33:0];
      cneg5_in = csum_ff[35] ^ nneg4_ff;
      nmag5_in = nmag4_ff;
      dmag5_in = dmag4_ff;
      dneg5_in = dneg4_ff;
      dz5_in   = dz4_ff;
      nz5_in   = nz4_ff;

      item_in.dnum_mag   = {nmag5_ff, 14'b0};
      item_in.det_mag    = dmag5_ff;
      item_in.depth_neg  = dneg5_ff;
      item_in.det_zero   = dz5_ff;
      item_in.cnum_mag   = sprp_pkg::DNUM_W'(screen_width[12:1])
                           * sprp_pkg::DNUM_W'(cmag5_ff);
      item_in.numy_mag   = nmag5_ff;
      item_in.center_neg = cneg5_ff;
      item_in.numy_zero  = nz5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
      if (adv) begin
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
         ssx_ff   <= ssx_in;
         csy_ff   <= csy_in;
         pysx_ff  <= pysx_in;
         pxsy_ff  <= pxsy_in;
         pxs_ff   <= pxs_in;
         cpy_ff   <= cpy_in;
         numx_ff  <= numx_in;
         numy_ff  <= numy_in;
         det_ff   <= det_in;
         csum_ff  <= csum_in;
         nmag4_ff <= nmag4_in;
         dmag4_ff <= dmag4_in;
         dneg4_ff <= dneg4_in;
         nneg4_ff <= nneg4_in;
         dz4_ff   <= dz4_in;
         nz4_ff   <= nz4_in;
         cmag5_ff <= cmag5_in;
         cneg5_ff <= cneg5_in;
         nmag5_ff <= nmag5_in;
         dmag5_ff <= dmag5_in;
         dneg5_ff <= dneg5_in;
         dz5_ff   <= dz5_in;
         nz5_ff   <= nz5_in;
         item_ff  <= item_in;
      end
   end
endmodule
`default_nettype wire

// ----- sv/sprp_queue.sv -----
// Two-entry queue between the front and back parts.
`default_nettype none
module sprp_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire sprp_pkg::item_type push_item,
   output logic                    full,
   input  wire logic               pop,
   output logic                    valid,
   output sprp_pkg::item_type      head
);
   sprp_pkg::item_type entry_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == 2'd2);
   assign valid = (cnt_ff != 2'd0);
   assign head  = entry_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         entry_ff[wr_ff] <= push_item;
      end
   end
endmodule
`default_nettype wire

// ----- sv/sprp_back.sv -----
// Back part: divisions, saturation, draw rectangle and result register.
`default_nettype none
module sprp_back #(
   parameter int TEX_WIDTH = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire sprp_pkg::item_type q_item,
   output logic                    q_pop,
   input  wire logic [12:0]        screen_width,
   input  wire logic [12:0]        screen_height,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output sprp_pkg::result_type    rsp_item
);
   localparam logic [20:0] TEX_NUM = 21'(TEX_WIDTH * 256);

   sprp_pkg::back_state_type state_ff, state_in;
   logic        valid_ff, valid_in;
   sprp_pkg::result_type res_ff, res_in;
   logic        dneg_ff, dneg_in, cneg_ff, cneg_in, dz_ff, dz_in, nz_ff, nz_in;
   logic signed [19:0] depth_ff, depth_in;
   logic signed [15:0] center_ff, center_in;
   logic [14:0] size_ff, size_in, voff_ff, voff_in;

   logic        start1, start2, done_a, done_b, done_c, done_d;
   logic [45:0] qa, qb;
   logic [20:0] qc, qd;
   logic        out_free;
   logic [13:0] half;
   logic signed [17:0] sty_f, stx_f, enx_f;
   logic [16:0] eny_f;
   logic [15:0] eny_c;
   logic signed [15:0] enx_c;

   sprp_div #(.N(sprp_pkg::DNUM_W), .M(sprp_pkg::DDEN_W)) u_div_depth (
      .clock(clock), .reset(reset), .start(start1),
      .dividend(q_item.dnum_mag), .divisor(q_item.det_mag),
      .quotient(qa), .done(done_a));

   sprp_div #(.N(sprp_pkg::DNUM_W), .M(sprp_pkg::DDEN_W)) u_div_center (
      .clock(clock), .reset(reset), .start(start1),
      .dividend(q_item.cnum_mag), .divisor(q_item.numy_mag),
      .quotient(qb), .done(done_b));

   sprp_div #(.N(21), .M(19)) u_div_size (
      .clock(clock), .reset(reset), .start(start2),
      .dividend({screen_height, 8'h00}), .divisor(depth_ff[18:0]),
      .quotient(qc), .done(done_c));

   sprp_div #(.N(21), .M(19)) u_div_voff (
      .clock(clock), .reset(reset), .start(start2),
      .dividend(TEX_NUM), .divisor(depth_ff[18:0]),
      .quotient(qd), .done(done_d));

   assign out_free   = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_item   = res_ff;

   always_comb begin
      state_in  = state_ff;
      valid_in  = valid_ff && !rsp_tready;
      res_in    = res_ff;
      dneg_in   = dneg_ff;
      cneg_in   = cneg_ff;
      dz_in     = dz_ff;
      nz_in     = nz_ff;
      depth_in  = depth_ff;
      center_in = center_ff;
      size_in   = size_ff;
      voff_in   = voff_ff;
      start1    = 1'b0;
      start2    = 1'b0;
      q_pop     = 1'b0;

      half  = size_ff[14:1];
      sty_f = 18'(screen_height[12:1]) + 18'(voff_ff) - 18'(half);
      eny_f = 17'(screen_height[12:1]) + 17'(half) + 17'(voff_ff);
      stx_f = 18'(center_ff) - 18'(half);
      enx_f = 18'(center_ff) + 18'(half);
      eny_c = (eny_f > 17'd32767) ? 16'd32767 : eny_f[15:0];
      if (eny_c >= {3'b000, screen_height}) begin
         eny_c = {3'b000, screen_height} - 16'd1;
      end
      enx_c = (enx_f > 18'sd32767) ? 16'sd32767 : enx_f[15:0];
      if (enx_c >= $signed({3'b000, screen_width})) begin
         enx_c = $signed({3'b000, screen_width} - 16'd1);
      end

      case (state_ff)
         sprp_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               start1   = 1'b1;
               dneg_in  = q_item.depth_neg;
               cneg_in  = q_item.center_neg;
               dz_in    = q_item.det_zero;
               nz_in    = q_item.numy_zero;
               state_in = sprp_pkg::ST_DIV1;
            end
         end
         sprp_pkg::ST_DIV1: begin
            if (done_a && done_b) begin
               if (dz_ff) begin
                  depth_in = '0;
               end else if (!dneg_ff) begin
                  depth_in = (qa > 46'd524287) ? 20'sd524287 : $signed(qa[19:0]);
               end else begin
                  depth_in = (qa > 46'd524288) ? -20'sd524288 : -$signed(qa[19:0]);
               end
               if (dz_ff || nz_ff) begin
                  center_in = '0;
               end else if (!cneg_ff) begin
                  center_in = (qb > 46'd32767) ? 16'sd32767 : $signed(qb[15:0]);
               end else begin
                  center_in = (qb > 46'd32768) ? -16'sd32768 : -$signed(qb[15:0]);
               end
               state_in = sprp_pkg::ST_START2;
            end
         end
         sprp_pkg::ST_START2: begin
            if (depth_ff > 20'sd0) begin
               start2   = 1'b1;
               state_in = sprp_pkg::ST_DIV2;
            end else begin
               size_in  = 15'd32767;
               voff_in  = 15'd32767;
               state_in = sprp_pkg::ST_RECT;
            end
         end
         sprp_pkg::ST_DIV2: begin
            if (done_c && done_d) begin
               size_in  = (qc > 21'd32767) ? 15'd32767 : qc[14:0];
               voff_in  = (qd > 21'd32767) ? 15'd32767 : qd[14:0];
               state_in = sprp_pkg::ST_RECT;
            end
         end
         sprp_pkg::ST_RECT: begin
            if (out_free) begin
               valid_in               = 1'b1;
               res_in.depth           = depth_ff;
               res_in.in_front        = (depth_ff > 20'sd0);
               res_in.center_column   = center_ff;
               res_in.sprite_size     = size_ff;
               res_in.vertical_offset = $signed({1'b0, voff_ff});
               res_in.start_y         = sty_f[17] ? 15'd0 :
                                        (sty_f > 18'sd32767) ? 15'd32767 : sty_f[14:0];
               res_in.end_y           = $signed(eny_c);
               res_in.start_x         = stx_f[17] ? 15'd0 :
                                        (stx_f > 18'sd32767) ? 15'd32767 : stx_f[14:0];
               res_in.end_x           = enx_c;
               state_in               = sprp_pkg::ST_IDLE;
            end
         end
         default: state_in = sprp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sprp_pkg::ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      res_ff    <= res_in;
      dneg_ff   <= dneg_in;
      cneg_ff   <= cneg_in;
      dz_ff     <= dz_in;
      nz_ff     <= nz_in;
      depth_ff  <= depth_in;
      center_ff <= center_in;
      size_ff   <= size_in;
      voff_ff   <= voff_in;
   end
endmodule
`default_nettype wire

// ----- sv/sprite_screen_projection.sv -----
// Top level of the sprite screen projection block.
// Path: the front pipeline, the queue, then the depth and center divisions, the size and
// offset divisions when the sprite is in front, and the result register.
// The bit-serial dividers of the back part take one word at a time, so a new word waits until
// the last is out; the front keeps accepting meanwhile until the queue and its stages are full.
// Reset (synchronous, active high) empties the pipeline and queue and loads register defaults.
`default_nettype none
module sprite_screen_projection #(
   parameter int TEX_WIDTH = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // Input words: [7:0] cell_x, [15:8] cell_y.
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [15:0]  req_tdata,
   // Result words: [19:0] depth, [20] in_front, [36:21] center_column,
   // [51:37] sprite_size, [67:52] vertical_offset, [82:68] start_x,
   // [98:83] end_x, [113:99] start_y, [129:114] end_y, [135:130] zero.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [135:0]      rsp_tdata,
   // Register writes.
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_addr,
   input  wire logic [15:0]  csr_wdata
);
   // Camera and screen registers; the user must change them only while the block is idle (unenforced).
   logic [15:0]        player_x_ff, player_y_ff;
   logic signed [15:0] dir_cos_ff, dir_sin_ff, plane_x_ff, plane_y_ff;
   logic [12:0]        width_ff, height_ff;

   logic               q_push, q_full, q_pop, q_valid;
   sprp_pkg::item_type push_item, head_item;
   sprp_pkg::result_type res;

   always_ff @(posedge clock) begin
      if (reset) begin
         player_x_ff <= 16'd0;
         player_y_ff <= 16'd0;
         dir_cos_ff  <= 16'sd16384;
         dir_sin_ff  <= 16'sd0;
         plane_x_ff  <= 16'sd0;
         plane_y_ff  <= 16'sd10813;
         width_ff    <= 13'd640;
         height_ff   <= 13'd480;
      end else if (csr_we) begin
         case (sprp_pkg::csr_idx_type'(csr_addr))
            sprp_pkg::CSR_PLAYER_X:      player_x_ff <= csr_wdata;
            sprp_pkg::CSR_PLAYER_Y:      player_y_ff <= csr_wdata;
            sprp_pkg::CSR_DIR_COS:       dir_cos_ff  <= $signed(csr_wdata);
            sprp_pkg::CSR_DIR_SIN:       dir_sin_ff  <= $signed(csr_wdata);
            sprp_pkg::CSR_PLANE_X:       plane_x_ff  <= $signed(csr_wdata);
            sprp_pkg::CSR_PLANE_Y:       plane_y_ff  <= $signed(csr_wdata);
            sprp_pkg::CSR_SCREEN_WIDTH:  width_ff    <= csr_wdata[12:0];
            sprp_pkg::CSR_SCREEN_HEIGHT: height_ff   <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   // The front pipeline forms the numerators and divisors of each word.
   sprp_front u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .cell_x(req_tdata[7:0]), .cell_y(req_tdata[15:8]),
      .player_x(player_x_ff), .player_y(player_y_ff),
      .dir_cos(dir_cos_ff), .dir_sin(dir_sin_ff),
      .plane_x(plane_x_ff), .plane_y(plane_y_ff),
      .screen_width(width_ff),
      .q_full(q_full), .q_push(q_push), .q_item(push_item));

   // The queue lets the front run ahead while the dividers are busy.
   sprp_queue u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .push_item(push_item), .full(q_full),
      .pop(q_pop), .valid(q_valid), .head(head_item));

   // The back part divides, saturates and holds the result word.
   sprp_back #(.TEX_WIDTH(TEX_WIDTH)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_item(head_item), .q_pop(q_pop),
      .screen_width(width_ff), .screen_height(height_ff),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_item(res));

   assign rsp_tdata = {6'b0, res};
endmodule
`default_nettype wire

// ----- sv/sprp_checker.sv -----
// Port checker for the sprite screen projection block, with its bind.
`default_nettype none
module sprp_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [135:0] rsp_tdata
);
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_front_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[20] == (!rsp_tdata[19] && (rsp_tdata[19:0] != 20'd0))))
      else $error("in_front disagrees with depth");

   a_behind_size: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[20] |-> (rsp_tdata[51:37] == 15'h7fff))
      else $error("sprite behind camera must have saturated size");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");
endmodule

bind sprite_screen_projection sprp_checker u_sprp_checker (
   .clock(clock), .reset(reset),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));
`default_nettype wire

// ----- verif/tb_sprite_screen_projection.sv -----
// Self-checking testbench of the sprite screen projection block, with its projection predictor.
`default_nettype none

// Holds the projected rectangles still owed by the block and checks each result word.
class projection_board;
   sprp_pkg::result_type owed_q[$];
   int unsigned errors;

   function new();
      errors = 0;
   endfunction

   function void note_sprite(sprp_pkg::result_type r);
      owed_q.push_back(r);
   endfunction

   function void check_word(sprp_pkg::result_type got);
      sprp_pkg::result_type exp;
      if (owed_q.size() == 0) begin
         $display("%0t: unexpected word %h", $realtime, got);
         errors++;
         return;
      end
      exp = owed_q.pop_front();
      if (got !== exp) begin
         errors++;
         $display("%0t: word mismatch expected %h actual %h", $realtime, exp, got);
         if (got.depth !== exp.depth)
            $display("%0t:  depth expected %0d actual %0d", $realtime, exp.depth, got.depth);
         if (got.in_front !== exp.in_front)
            $display("%0t:  in_front expected %0d actual %0d", $realtime, exp.in_front,
                     got.in_front);
         if (got.center_column !== exp.center_column)
            $display("%0t:  center_column expected %0d actual %0d", $realtime,
                     exp.center_column, got.center_column);
         if (got.sprite_size !== exp.sprite_size)
            $display("%0t:  sprite_size expected %0d actual %0d", $realtime,
                     exp.sprite_size, got.sprite_size);
         if (got.vertical_offset !== exp.vertical_offset)
            $display("%0t:  vertical_offset expected %0d actual %0d", $realtime,
                     exp.vertical_offset, got.vertical_offset);
         if (got.start_x !== exp.start_x)
            $display("%0t:  start_x expected %0d actual %0d", $realtime, exp.start_x,
                     got.start_x);
         if (got.end_x !== exp.end_x)
            $display("%0t:  end_x expected %0d actual %0d", $realtime, exp.end_x, got.end_x);
         if (got.start_y !== exp.start_y)
            $display("%0t:  start_y expected %0d actual %0d", $realtime, exp.start_y,
                     got.start_y);
         if (got.end_y !== exp.end_y)
            $display("%0t:  end_y expected %0d actual %0d", $realtime, exp.end_y, got.end_y);
      end
   endfunction
endclass

module tb_sprite_screen_projection;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TEX_W = 64;
   // Limit on the whole run; crossing it ends the test as a mismatch.
   localparam longint CYCLE_LIMIT = 2_000_000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [15:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [135:0] rsp_tdata;
   logic         csr_we;
   logic [2:0]   csr_addr;
   logic [15:0]  csr_wdata;

   sprite_screen_projection #(.TEX_WIDTH(TEX_W)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   projection_board board;

   // Camera registers as the predictor sees them.
   logic [15:0] cam_px, cam_py, cam_cos, cam_sin, cam_plx, cam_ply;
   logic [12:0] scr_w, scr_h;

   longint cycles;
   bit     hold_off;   // Set while the receiver is forced into a long stall.

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   // Projects one sprite cell through the current camera, exactly as the block should.
   function automatic sprp_pkg::result_type project_sprite(logic [7:0] cx, logic [7:0] cy);
      sprp_pkg::result_type r;
      longint c, s, plx, ply, w, h, sx, sy, det, numx, numy;
      longint depth, center, size, voff, half, sty, eny, stx, enx;
      bit front;
      c = longint'($signed(cam_cos));
      s = longint'($signed(cam_sin));
      plx = longint'($signed(cam_plx));
      ply = longint'($signed(cam_ply));
      w = scr_w;
      h = scr_h;
      sx = longint'(cx) * 256 + 128 - longint'(cam_px);
      sy = longint'(cy) * 256 + 128 - longint'(cam_py);
      det = plx * s - c * ply;
      numx = s * sx - c * sy;
      numy = -ply * sx + plx * sy;
      depth = 0;
      center = 0;
      // Division of longints truncates toward zero, as the block does.
      if (det != 0) begin
         depth = clip((numy * 16384) / det, -524288, 524287);
         if (numy != 0)
            center = clip(((w / 2) * (numy + numx)) / numy, -32768, 32767);
      end
      front = depth > 0;
      if (front) begin
         size = clip((h * 256) / depth, 0, 32767);
         voff = clip((longint'(TEX_W) * 256) / depth, -32768, 32767);
      end else begin
         // Behind the camera or degenerate: both sizes saturate.
         size = 32767;
         voff = 32767;
      end
      half = size / 2;
      sty = clip(h / 2 - half + voff, 0, 32767);
      eny = clip(h / 2 + half + voff, -32768, 32767);
      if (eny >= h) eny = h - 1;
      stx = clip(center - half, 0, 32767);
      enx = clip(center + half, -32768, 32767);
      if (enx >= w) enx = w - 1;
      r.depth = depth[19:0];
      r.in_front = front;
      r.center_column = center[15:0];
      r.sprite_size = size[14:0];
      r.vertical_offset = voff[15:0];
      r.start_x = stx[14:0];
      r.end_x = enx[15:0];
      r.start_y = sty[14:0];
      r.end_y = eny[15:0];
      return r;
   endfunction

   // Writes one camera register; only called while nothing is in flight.
   task automatic write_reg(sprp_pkg::csr_idx_type idx, logic [15:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         sprp_pkg::CSR_PLAYER_X:      cam_px = val;
         sprp_pkg::CSR_PLAYER_Y:      cam_py = val;
         sprp_pkg::CSR_DIR_COS:       cam_cos = val;
         sprp_pkg::CSR_DIR_SIN:       cam_sin = val;
         sprp_pkg::CSR_PLANE_X:       cam_plx = val;
         sprp_pkg::CSR_PLANE_Y:       cam_ply = val;
         sprp_pkg::CSR_SCREEN_WIDTH:  scr_w = val[12:0];
         sprp_pkg::CSR_SCREEN_HEIGHT: scr_h = val[12:0];
         default: ;
      endcase
   endtask

   // Writes all camera registers back to back, then drops the write enable.
   task automatic load_camera(logic [15:0] px, logic [15:0] py, logic [15:0] c,
                              logic [15:0] s, logic [15:0] plx, logic [15:0] ply,
                              logic [15:0] w, logic [15:0] h);
      write_reg(sprp_pkg::CSR_PLAYER_X, px);
      write_reg(sprp_pkg::CSR_PLAYER_Y, py);
      write_reg(sprp_pkg::CSR_DIR_COS, c);
      write_reg(sprp_pkg::CSR_DIR_SIN, s);
      write_reg(sprp_pkg::CSR_PLANE_X, plx);
      write_reg(sprp_pkg::CSR_PLANE_Y, ply);
      write_reg(sprp_pkg::CSR_SCREEN_WIDTH, w);
      write_reg(sprp_pkg::CSR_SCREEN_HEIGHT, h);
      csr_we <= 1'b0;
   endtask

   // Offers one sprite cell after a random gap and waits for the block to take the word.
   // Valid stays high after the accept so that a word with no gap follows directly.
   task automatic send_sprite(logic [7:0] cx, logic [7:0] cy, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {cy, cx};
      do @(posedge clock); while (!req_tready);
      board.note_sprite(project_sprite(cx, cy));
   endtask

   // Waits until every owed word is back, then lets the pipeline drain.
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (board.owed_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // Receiver: random stalls between accepts, and one long hold-off on request.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (2000) @(posedge clock);
            hold_off = 0;
         end
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: checks every accepted result word against the oldest prediction.
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_word(rsp_tdata[$bits(sprp_pkg::result_type)-1:0]);

   initial begin
      int n;
      board = new();
      cycles = 0;
      hold_off = 0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_we <= 1'b0;
      csr_addr <= sprp_pkg::CSR_PLAYER_X;
      csr_wdata <= '0;
      cam_px = 0; cam_py = 0; cam_cos = 16384; cam_sin = 0;
      cam_plx = 0; cam_ply = 10813; scr_w = 640; scr_h = 480;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part with reset defaults: field extremes and the corners of the map.
      send_sprite(8'd0, 8'd0);
      send_sprite(8'hFF, 8'hFF);
      send_sprite(8'hFF, 8'd0);
      send_sprite(8'd0, 8'hFF);
      send_sprite(8'h55, 8'hAA);
      send_sprite(8'hAA, 8'h55);
      drain_block();

      // Player in the middle: sprites behind, level with the camera, and in front.
      load_camera(16'h8080, 16'h8080, 16'd16384, 16'd0, 16'd0, 16'd10813, 16'd640, 16'd480);
      send_sprite(8'h70, 8'h80);   // behind the camera
      send_sprite(8'h80, 8'h80);   // on the player: level with the camera
      send_sprite(8'h81, 8'h80);   // very close in front
      send_sprite(8'h90, 8'h85);
      send_sprite(8'h84, 8'h7C);
      drain_block();

      // Degenerate camera: all zero vectors.
      load_camera(16'h1000, 16'h1000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd640, 16'd480);
      send_sprite(8'h20, 8'h20);
      send_sprite(8'h05, 8'hF0);
      drain_block();

      // Extreme vectors and screen sizes, including zero and the widest values.
      load_camera(16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                  16'd4096, 16'd1);
      send_sprite(8'd0, 8'hFF);
      send_sprite(8'hFF, 8'd0);
      send_sprite(8'h10, 8'h10);
      drain_block();
      load_camera(16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                  16'd0, 16'h1FFF);
      send_sprite(8'h00, 8'h00);
      send_sprite(8'hFF, 8'hFF);
      send_sprite(8'h80, 8'h40);
      drain_block();

      // Random phases, each with a fresh camera; most cameras are well formed rotations.
      for (int ph = 0; ph < 15; ph++) begin
         if ($urandom_range(0, 3) != 0) begin
            int ang;
            real a, cs, sn, fov;
            ang = $urandom_range(0, 359);
            a = ang * 3.14159265358979 / 180.0;
            cs = $cos(a);
            sn = $sin(a);
            fov = 0.3 + $urandom_range(0, 70) / 100.0;
            load_camera(16'($urandom), 16'($urandom),
                        16'($rtoi(cs * 16384.0)), 16'($rtoi(sn * 16384.0)),
                        16'($rtoi(-sn * fov * 16384.0)), 16'($rtoi(cs * fov * 16384.0)),
                        16'($urandom_range(1, 4096)), 16'($urandom_range(1, 4096)));
         end else begin
            load_camera(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
         end
         n = 100;
         for (int i = 0; i < n; i++) begin
            logic [7:0] bx, by;
            bx = cam_px[15:8];
            by = cam_py[15:8];
            // Most sprites sit near the player so the projection stays on screen.
            if ($urandom_range(0, 3) != 0)
               send_sprite(bx + 8'($urandom_range(0, 16)) - 8'd8,
                           by + 8'($urandom_range(0, 16)) - 8'd8);
            else
               send_sprite(8'($urandom), 8'($urandom));
         end
         // Once, stall the receiver for a long stretch while sprites keep coming.
         if (ph == 3) begin
            hold_off = 1;
            for (int i = 0; i < 40; i++) send_sprite(8'($urandom), 8'($urandom), 1);
         end
         drain_block();
      end

      if (board.errors == 0 && board.owed_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
`default_nettype wire
